/* sv/crp_pkg.sv */
// Shared types and codes for the clock page replacement block.
// No dependencies; used by crp_ctrl, crp_dp and clock_page_replacement.
package crp_pkg;

	localparam logic [1:0] FUNC_ACCESS  = 2'd0;
	localparam logic [1:0] FUNC_FILL    = 2'd1;
	localparam logic [1:0] FUNC_RELEASE = 2'd2;
	localparam logic [1:0] FUNC_VICTIM  = 2'd3;

	localparam logic POLICY_FIFO  = 1'b0;
	localparam logic POLICY_CLOCK = 1'b1;

	typedef struct packed {
		logic [1:0] func;
		logic [4:0] frame_index;
		logic       is_write;
	} crp_in_t;

	typedef struct packed {
		logic       victim_valid;
		logic [4:0] victim_frame;
		logic       needs_writeback;
	} crp_out_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_UPDATE,
		CMD_SCAN,
		CMD_FALLBACK,
		CMD_TAKE,
		CMD_TAKE_FB
	} crp_op_t;

	typedef struct packed {
		crp_op_t op;
	} crp_cmd_t;

	typedef struct packed {
		logic is_req;
		logic mode;
		logic hit;
		logic last;
	} crp_status_t;

endpackage

/* sv/crp_dp.sv */
// Datapath: frame state bits, clock hand, scan pointer, policy register, result register.
// Depends on crp_pkg; driven by crp_ctrl commands.
module crp_dp #(
	parameter int NUM_FRAMES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crp_pkg::crp_in_t     in_data,
	input  logic                 cfg_we,
	input  logic                 cfg_data,
	input  crp_pkg::crp_cmd_t    cmd,
	output crp_pkg::crp_status_t status,
	output crp_pkg::crp_out_t    out_data
);
	import crp_pkg::*;

	localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam logic [IW-1:0] LAST_FRAME = IW'(NUM_FRAMES - 1);
	localparam logic [IW-1:0] ONE_FRAME = IW'(1);
	localparam logic [1:0] PASS_CLEAR = 2'd1;
	localparam logic [1:0] PASS_FINAL = 2'd3;

	logic [NUM_FRAMES-1:0] occ_q, use_q, dirty_q;
	logic [IW-1:0]         hand_q, ptr_q, cnt_q;
	logic [1:0]            pass_q;
	logic                  mode_q;
	logic [1:0]            func_q;
	logic                  wr_q, in_range_q;
	crp_out_t              out_q;

	logic [IW-1:0] ptr_next, hand_next;
	logic          hit;

	assign ptr_next  = (ptr_q == LAST_FRAME) ? '0 : ptr_q + ONE_FRAME;
	assign hand_next = (hand_q == LAST_FRAME) ? '0 : hand_q + ONE_FRAME;
	assign hit = occ_q[ptr_q] & ~use_q[ptr_q] & (dirty_q[ptr_q] == pass_q[0]);

	assign status.is_req = (func_q == FUNC_VICTIM);
	assign status.mode   = mode_q;
	assign status.hit    = hit;
	assign status.last   = (pass_q == PASS_FINAL) && (cnt_q == LAST_FRAME);
	assign out_data      = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= POLICY_CLOCK;
		end else if (cfg_we) begin
			mode_q  <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			use_q   <= '0;
			dirty_q <= '0;
			hand_q  <= '0;
		end else begin
			case (cmd.op)
				CMD_UPDATE: begin
					if (in_range_q) begin
						case (func_q)
							FUNC_ACCESS: begin
								if (occ_q[ptr_q]) begin
									use_q[ptr_q] <= 1'b1;
									if (wr_q)
										dirty_q[ptr_q] <= 1'b1;
								end
							end
							FUNC_FILL: begin
								occ_q[ptr_q]   <= 1'b1;
								use_q[ptr_q]   <= 1'b0;
								dirty_q[ptr_q] <= 1'b0;
							end
							FUNC_RELEASE: begin
								occ_q[ptr_q]   <= 1'b0;
								use_q[ptr_q]   <= 1'b0;
								dirty_q[ptr_q] <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				CMD_SCAN: begin
					if (!hit && pass_q == PASS_CLEAR && occ_q[ptr_q])
						use_q[ptr_q] <= 1'b0;
				end
				CMD_TAKE, CMD_TAKE_FB: begin
					occ_q[ptr_q]   <= 1'b1;
					use_q[ptr_q]   <= 1'b0;
					dirty_q[ptr_q] <= 1'b0;
					hand_q         <= (cmd.op == CMD_TAKE) ? ptr_next : ptr_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_LOAD: begin
				func_q     <= in_data.func;
				wr_q       <= in_data.is_write;
				in_range_q <= (32'(in_data.frame_index) < NUM_FRAMES);
				ptr_q      <= (in_data.func == FUNC_VICTIM) ? hand_q : IW'(in_data.frame_index);
				cnt_q      <= '0;
				pass_q     <= '0;
			end
			CMD_SCAN: begin
				if (!hit) begin
					ptr_q <= ptr_next;
					if (cnt_q == LAST_FRAME) begin
						cnt_q  <= '0;
						pass_q <= pass_q + 2'd1;
					end else begin
						cnt_q <= cnt_q + ONE_FRAME;
					end
				end
			end
			CMD_FALLBACK: begin
				ptr_q <= hand_next;
			end
			CMD_UPDATE: begin
				out_q <= '0;
			end
			CMD_TAKE, CMD_TAKE_FB: begin
				out_q.victim_valid    <= 1'b1;
				out_q.victim_frame    <= 5'(ptr_q);
				out_q.needs_writeback <= dirty_q[ptr_q];
			end
			default: ;
		endcase
	end

endmodule

/* sv/crp_ctrl.sv */
// Controller FSM: input/output handshake and sequencing of datapath commands.
// Depends on crp_pkg; drives crp_dp.
module crp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  crp_pkg::crp_status_t status,
	output crp_pkg::crp_cmd_t    cmd
);
	import crp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_UPDATE,
		S_SCAN,
		S_FALLBACK,
		S_TAKE,
		S_TAKE_FB
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   out_load;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = out_free &&
		(state_q == S_UPDATE || state_q == S_TAKE || state_q == S_TAKE_FB);
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.op = CMD_NONE;
		case (state_q)
			S_IDLE:     if (in_valid) cmd.op = CMD_LOAD;
			S_UPDATE:   if (out_free) cmd.op = CMD_UPDATE;
			S_SCAN:     cmd.op = CMD_SCAN;
			S_FALLBACK: cmd.op = CMD_FALLBACK;
			S_TAKE:     if (out_free) cmd.op = CMD_TAKE;
			S_TAKE_FB:  if (out_free) cmd.op = CMD_TAKE_FB;
			default:    cmd.op = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					if (!status.is_req)
						state_q <= S_UPDATE;
					else if (status.mode == POLICY_FIFO)
						state_q <= S_TAKE;
					else
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (status.hit)
						state_q <= S_TAKE;
					else if (status.last)
						state_q <= S_FALLBACK;
				end
				S_FALLBACK: state_q <= S_TAKE_FB;
				S_UPDATE, S_TAKE, S_TAKE_FB: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* sv/clock_page_replacement.sv */
// Top level of the enhanced second-chance clock page replacement block.
// Depends on crp_pkg, crp_ctrl and crp_dp.
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   in_data   (crp_in_t)
//  out      output     out_valid/out_stall out_data  (crp_out_t)
//  cfg      input      cfg_we              cfg_data  (policy_mode)
//
// Access, fill, release and FIFO victim request: dispatch, then update or take into the result.
// Clock victim request: dispatch, then k frames examined by the one-frame-per-cycle scan,
// at most 4*NUM_FRAMES, then take; no occupied frame adds a fallback step before take.
// Reset clears all frame bits and the hand at once; policy resets to clock mode.
// One item in flight; a pending result waits in the output register, and the next
// item is taken meanwhile but finishes only once that result is transferred.
module clock_page_replacement #(
	parameter int NUM_FRAMES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  crp_pkg::crp_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output crp_pkg::crp_out_t out_data,
	input  logic              cfg_we,
	input  logic              cfg_data
);
	import crp_pkg::*;

	crp_cmd_t    cmd;
	crp_status_t status;

	crp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	crp_dp #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule

/* verif/tb.sv */
// Self-checking testbench for clock_page_replacement: random and directed page operations
// are checked against a built-in model of the frame bits and the replacement hand.
// Depends on crp_pkg and the clock_page_replacement RTL.
module tb;
	import crp_pkg::*;

	localparam int FRAMES     = 32;
	localparam int IDLE_LIMIT = 3000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	crp_in_t  in_data = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	crp_out_t out_data;
	logic     cfg_we = 1'b0;
	logic     cfg_data = 1'b0;

	clock_page_replacement #(.NUM_FRAMES(FRAMES)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// model state
	logic              policy = POLICY_CLOCK;
	logic [4:0]        hand_pos = '0;
	logic [FRAMES-1:0] frame_used = '0;
	logic [FRAMES-1:0] frame_dirty = '0;
	logic [FRAMES-1:0] frame_occupied = '0;

	crp_in_t  page_ops[$];
	crp_out_t victim_reports[$];
	int       mismatches = 0;
	logic     in_fire = 1'b0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       stall_pct = 0;
	int       stall_span = 0;
	int       idle_cycles = 0;

	task automatic apply_page_op(input crp_in_t op, output crp_out_t rep);
		int         pass;
		int         n;
		logic [4:0] p;
		logic [4:0] victim;
		logic       found;
		logic       want_dirty;
		rep = '0;
		if (op.func == FUNC_VICTIM) begin
			if (policy == POLICY_FIFO) begin
				victim = hand_pos;
				hand_pos = hand_pos + 5'd1;
			end else begin
				found = 1'b0;
				victim = '0;
				for (pass = 1; pass <= 4 && !found; pass++) begin
					p = hand_pos;
					want_dirty = (pass == 2 || pass == 4);
					for (n = 0; n < FRAMES && !found; n++) begin
						if (frame_occupied[p]) begin
							if (!frame_used[p] && frame_dirty[p] == want_dirty) begin
								found = 1'b1;
								victim = p;
							end else if (pass == 2) begin
								frame_used[p] = 1'b0;
							end
						end
						p = p + 5'd1;
					end
				end
				if (found) begin
					hand_pos = victim + 5'd1;
				end else begin
					hand_pos = hand_pos + 5'd1;
					victim = hand_pos;
				end
			end
			rep.victim_valid = 1'b1;
			rep.victim_frame = victim;
			rep.needs_writeback = frame_dirty[victim];
			frame_occupied[victim] = 1'b1;
			frame_used[victim] = 1'b0;
			frame_dirty[victim] = 1'b0;
		end else begin
			case (op.func)
				FUNC_ACCESS: begin
					if (frame_occupied[op.frame_index]) begin
						frame_used[op.frame_index] = 1'b1;
						if (op.is_write)
							frame_dirty[op.frame_index] = 1'b1;
					end
				end
				FUNC_FILL: begin
					frame_occupied[op.frame_index] = 1'b1;
					frame_used[op.frame_index] = 1'b0;
					frame_dirty[op.frame_index] = 1'b0;
				end
				default: begin
					frame_occupied[op.frame_index] = 1'b0;
					frame_used[op.frame_index] = 1'b0;
					frame_dirty[op.frame_index] = 1'b0;
				end
			endcase
		end
	endtask

	function automatic crp_in_t make_op(logic [1:0] func, int frame, logic wr);
		crp_in_t op;
		op.func = func;
		op.frame_index = frame[4:0];
		op.is_write = wr;
		return op;
	endfunction

	task automatic queue_random_ops(input int count);
		int         i;
		int         f;
		int         r;
		logic [1:0] func;
		i = 0;
		while (i < count) begin
			r = $urandom_range(99);
			if (r < 3) begin
				// drain every frame, then ask for a victim with none occupied
				for (f = 0; f < FRAMES; f++)
					page_ops.push_back(make_op(FUNC_RELEASE, f, 1'($urandom_range(1))));
				page_ops.push_back(make_op(FUNC_VICTIM, $urandom_range(31),
					1'($urandom_range(1))));
				i += FRAMES + 1;
			end else begin
				r = $urandom_range(99);
				if (r < 40)
					func = FUNC_ACCESS;
				else if (r < 60)
					func = FUNC_FILL;
				else if (r < 70)
					func = FUNC_RELEASE;
				else
					func = FUNC_VICTIM;
				page_ops.push_back(make_op(func, $urandom_range(31), 1'($urandom_range(1))));
				i++;
			end
		end
	endtask

	task automatic wait_drained();
		while (page_ops.size() != 0 || victim_reports.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	task automatic set_policy(input logic mode);
		wait_drained();
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= mode;
		policy = mode;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: clock mode from reset
		page_ops.push_back(make_op(FUNC_VICTIM, 0, 1'b0));
		page_ops.push_back(make_op(FUNC_FILL, 0, 1'b0));
		page_ops.push_back(make_op(FUNC_FILL, 31, 1'b0));
		page_ops.push_back(make_op(FUNC_ACCESS, 31, 1'b1));
		page_ops.push_back(make_op(FUNC_ACCESS, 0, 1'b0));
		page_ops.push_back(make_op(FUNC_ACCESS, 10, 1'b1));
		page_ops.push_back(make_op(FUNC_VICTIM, 0, 1'b0));
		page_ops.push_back(make_op(FUNC_ACCESS, 1, 1'b1));
		page_ops.push_back(make_op(FUNC_VICTIM, 0, 1'b0));
		page_ops.push_back(make_op(FUNC_RELEASE, 31, 1'b0));
		page_ops.push_back(make_op(FUNC_RELEASE, 0, 1'b0));
		page_ops.push_back(make_op(FUNC_RELEASE, 1, 1'b0));
		page_ops.push_back(make_op(FUNC_VICTIM, 0, 1'b0));
		page_ops.push_back(make_op(FUNC_RELEASE, 2, 1'b0));
		page_ops.push_back(make_op(FUNC_FILL, 5, 1'b1));
		page_ops.push_back(make_op(FUNC_ACCESS, 5, 1'b1));
		page_ops.push_back(make_op(FUNC_VICTIM, 0, 1'b0));
		page_ops.push_back(make_op(FUNC_VICTIM, 31, 1'b1));
		page_ops.push_back(make_op(FUNC_ACCESS, 31, 1'b0));
		page_ops.push_back(make_op(FUNC_FILL, 31, 1'b1));
		page_ops.push_back(make_op(FUNC_ACCESS, 31, 1'b1));
		page_ops.push_back(make_op(FUNC_VICTIM, 0, 1'b0));

		set_policy(POLICY_FIFO);
		queue_random_ops(350);
		set_policy(POLICY_CLOCK);
		queue_random_ops(550);
		set_policy(POLICY_FIFO);
		queue_random_ops(300);
		set_policy(POLICY_CLOCK);
		queue_random_ops(600);

		wait_drained();
		repeat (150) @(posedge clk);
		if (mismatches == 0 && victim_reports.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// input side: accept and predict at the rising edge
	always @(posedge clk) begin : take_ops
		crp_out_t rep;
		in_fire <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			apply_page_op(in_data, rep);
			victim_reports.push_back(rep);
			void'(page_ops.pop_front());
		end
	end

	// sender bursts and gaps
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (page_ops.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= page_ops[0];
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, including stall-free stretches
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_span = $urandom_range(20, 300);
			case ($urandom_range(4))
				0, 1: stall_pct = 0;
				2: stall_pct = 25;
				3: stall_pct = 50;
				default: stall_pct = 80;
			endcase
		end else begin
			stall_span--;
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : check_results
		crp_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (victim_reports.size() == 0) begin
				$error("unexpected result transfer: %p", out_data);
				mismatches++;
			end else begin
				want = victim_reports.pop_front();
				if (out_data.victim_valid !== want.victim_valid) begin
					$error("victim_valid: expected %0d, got %0d",
						want.victim_valid, out_data.victim_valid);
					mismatches++;
				end
				if (out_data.victim_frame !== want.victim_frame) begin
					$error("victim_frame: expected %0d, got %0d",
						want.victim_frame, out_data.victim_frame);
					mismatches++;
				end
				if (out_data.needs_writeback !== want.needs_writeback) begin
					$error("needs_writeback: expected %0d, got %0d",
						want.needs_writeback, out_data.needs_writeback);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
